FILE: design/hus_pkg.sv
// shared types and constants of the url splitter
package hus_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PortW  = 16;
  localparam int unsigned PartW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [PortW-1:0] HttpPortReset  = 16'd80;
  localparam logic [PortW-1:0] HttpsPortReset = 16'd443;

  localparam logic [CfgIdxW-1:0] CfgHttpPort  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHttpsPort = 8'd1;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StNoSup = 2'd1;
  localparam logic [StatW-1:0] StInval = 2'd2;

  localparam logic [PartW-1:0] PartOther = 2'd0;
  localparam logic [PartW-1:0] PartHost  = 2'd1;
  localparam logic [PartW-1:0] PartPath  = 2'd2;

  localparam logic [0:0] SchemeHttps = 1'b0;
  localparam logic [0:0] SchemeHttp  = 1'b1;

  localparam logic [ByteW-1:0] ChH     = 8'h68;
  localparam logic [ByteW-1:0] ChT     = 8'h74;
  localparam logic [ByteW-1:0] ChP     = 8'h70;
  localparam logic [ByteW-1:0] ChS     = 8'h73;
  localparam logic [ByteW-1:0] ChColon = 8'h3a;
  localparam logic [ByteW-1:0] ChSlash = 8'h2f;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_end;
    logic             is_colon;
    logic             is_slash;
    logic             is_digit;
    logic [3:0]       digit;
    logic             is_h;
    logic             is_t;
    logic             is_p;
    logic             is_s;
  } char_class_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [PartW-1:0] part;
    logic             done_res;
    logic [StatW-1:0] status;
    logic             scheme_id;
    logic [PortW-1:0] port_number;
  } result_t;

endpackage

FILE: design/hus_queue.sv
// small register queue with push/full and pop/empty sides
module hus_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: design/hus_front.sv
// input side: byte classification ahead of the request queue
module hus_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic [hus_pkg::ByteW-1:0]  char_in_i,
  output logic                       full,
  input  logic                       cls_pop_i,
  output hus_pkg::char_class_t       cls_o,
  output logic                       cls_empty_o
);
  import hus_pkg::*;

  parameter int unsigned Depth = QueueDepth;

  char_class_t cls;

  always_comb begin
    cls          = '0;
    cls.data     = char_in_i;
    cls.is_end   = (char_in_i == '0);
    cls.is_colon = (char_in_i == ChColon);
    cls.is_slash = (char_in_i == ChSlash);
    cls.is_digit = (char_in_i >= ChZero) && (char_in_i <= ChNine);
    cls.digit    = char_in_i[3:0];
    cls.is_h     = (char_in_i == ChH);
    cls.is_t     = (char_in_i == ChT);
    cls.is_p     = (char_in_i == ChP);
    cls.is_s     = (char_in_i == ChS);
  end

  hus_queue #(
    .Width($bits(char_class_t)),
    .Depth(Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls),
    .full_o  (full),
    .pop_i   (cls_pop_i),
    .rdata_o (cls_o),
    .empty_o (cls_empty_o)
  );

endmodule

FILE: design/hus_back.sv
// parse state machine, default port registers and result queue
module hus_back #(
  parameter int unsigned Depth = hus_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hus_pkg::char_class_t        cls_i,
  input  logic                        cls_empty_i,
  output logic                        cls_pop_o,
  input  logic                        cfg_valid_i,
  input  logic [hus_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hus_pkg::PortW-1:0]   cfg_data_i,
  input  logic                        pop,
  output logic                        empty,
  output hus_pkg::result_t            res_o
);
  import hus_pkg::*;

  localparam logic [2:0] PhScheme = 3'd0;
  localparam logic [2:0] PhSep    = 3'd1;
  localparam logic [2:0] PhHost   = 3'd2;
  localparam logic [2:0] PhPort   = 3'd3;
  localparam logic [2:0] PhSkip   = 3'd4;
  localparam logic [2:0] PhPath   = 3'd5;
  localparam logic [2:0] PhError  = 3'd6;

  logic [2:0]       phase_q, phase_d;
  logic [2:0]       pos_q, pos_d;
  logic             https_q, https_d;
  logic [PortW-1:0] acc_q, acc_d;
  logic             has_dig_q, has_dig_d;
  logic             given_q, given_d;
  logic [StatW-1:0] err_q, err_d;
  logic [PortW-1:0] http_port_q, https_port_q;

  logic             res_full, step;
  logic             letter_ok;
  logic [PortW+3:0] acc_next;
  result_t          res;

  assign step      = !cls_empty_i && !res_full;
  assign cls_pop_o = step;

  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, cls_i.digit};

  always_comb begin
    case (pos_q)
      3'd0:    letter_ok = cls_i.is_h;
      3'd1:    letter_ok = cls_i.is_t;
      3'd2:    letter_ok = cls_i.is_t;
      3'd3:    letter_ok = cls_i.is_p;
      default: letter_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    https_d   = https_q;
    acc_d     = acc_q;
    has_dig_d = has_dig_q;
    given_d   = given_q;
    err_d     = err_q;
    res       = '0;
    res.data_byte = cls_i.data;
    if (cls_i.is_end) begin
      res.done_res = 1'b1;
      case (phase_q)
        PhScheme: res.status = (pos_q < 3'd4) ? StNoSup : StInval;
        PhSep:    res.status = (pos_q == 3'd0) ? StInval : StNoSup;
        PhPort:   res.status = has_dig_q ? StOk : StInval;
        PhError:  res.status = err_q;
        default:  res.status = StOk;
      endcase
      if (res.status == StOk) begin
        res.scheme_id = https_q ? SchemeHttps : SchemeHttp;
        if (given_q) begin
          res.port_number = acc_q;
        end else begin
          res.port_number = https_q ? https_port_q : http_port_q;
        end
      end
      phase_d   = PhScheme;
      pos_d     = '0;
      https_d   = 1'b0;
      acc_d     = '0;
      has_dig_d = 1'b0;
      given_d   = 1'b0;
      err_d     = StOk;
    end else begin
      case (phase_q)
        PhScheme: begin
          if (pos_q < 3'd4) begin
            if (letter_ok) begin
              pos_d = pos_q + 1'b1;
            end else begin
              phase_d = PhError;
              err_d   = StNoSup;
            end
          end else if (cls_i.is_s) begin
            https_d = 1'b1;
            phase_d = PhSep;
            pos_d   = 3'd0;
          end else if (cls_i.is_colon) begin
            https_d = 1'b0;
            phase_d = PhSep;
            pos_d   = 3'd1;
          end else begin
            phase_d = PhError;
            err_d   = StInval;
          end
        end
        PhSep: begin
          if (pos_q == 3'd0) begin
            if (cls_i.is_colon) begin
              pos_d = 3'd1;
            end else begin
              phase_d = PhError;
              err_d   = StInval;
            end
          end else if (cls_i.is_slash) begin
            if (pos_q == 3'd1) begin
              pos_d = 3'd2;
            end else begin
              phase_d = PhHost;
            end
          end else begin
            phase_d = PhError;
            err_d   = StNoSup;
          end
        end
        PhHost: begin
          if (cls_i.is_colon) begin
            given_d = 1'b1;
            phase_d = PhPort;
          end else if (cls_i.is_slash) begin
            phase_d  = PhPath;
            res.part = PartPath;
          end else begin
            res.part = PartHost;
          end
        end
        PhPort: begin
          if (cls_i.is_digit) begin
            has_dig_d = 1'b1;
            if (acc_next[PortW+3:PortW] != '0) begin
              phase_d = PhError;
              err_d   = StInval;
            end else begin
              acc_d = acc_next[PortW-1:0];
            end
          end else if (!has_dig_q) begin
            phase_d = PhError;
            err_d   = StInval;
          end else if (cls_i.is_slash) begin
            phase_d  = PhPath;
            res.part = PartPath;
          end else begin
            phase_d = PhSkip;
          end
        end
        PhSkip: begin
          if (cls_i.is_slash) begin
            phase_d  = PhPath;
            res.part = PartPath;
          end
        end
        PhPath: res.part = PartPath;
        default: res.part = PartOther;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhScheme;
      pos_q     <= '0;
      https_q   <= 1'b0;
      acc_q     <= '0;
      has_dig_q <= 1'b0;
      given_q   <= 1'b0;
      err_q     <= StOk;
    end else if (step) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      https_q   <= https_d;
      acc_q     <= acc_d;
      has_dig_q <= has_dig_d;
      given_q   <= given_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      http_port_q  <= HttpPortReset;
      https_port_q <= HttpsPortReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgHttpPort) begin
        http_port_q <= cfg_data_i;
      end else if (cfg_index_i == CfgHttpsPort) begin
        https_port_q <= cfg_data_i;
      end
    end
  end

  hus_queue #(
    .Width($bits(result_t)),
    .Depth(Depth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

FILE: design/http_url_splitter.sv
// top level of the url splitter: byte classifier, request queue and parser
// The block takes one URL byte per request (a zero byte ends the URL) and
// returns one result per byte: the byte, its part tag (host, path or
// other) and, on the terminating byte, status, scheme and port. One byte
// is taken every cycle while full is low, then passes the request queue,
// parse step and result queue. Errors show only on the terminating result,
// so tagged bytes of a URL whose status is not ok should be dropped. The
// default ports are written through the configuration channel only while
// the block is idle; the user, not the block, ensures it.
module http_url_splitter #(
  parameter int unsigned QueueDepth = hus_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [hus_pkg::ByteW-1:0]   char_in_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [hus_pkg::ByteW-1:0]   data_byte_o,
  output logic [hus_pkg::PartW-1:0]   part_o,
  output logic                        done_res_o,
  output logic [hus_pkg::StatW-1:0]   status_o,
  output logic                        scheme_id_o,
  output logic [hus_pkg::PortW-1:0]   port_number_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hus_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hus_pkg::PortW-1:0]   cfg_data_i
);
  import hus_pkg::*;

  char_class_t cls;
  logic        cls_empty, cls_pop;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  hus_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .char_in_i   (char_in_i),
    .full        (full),
    .cls_pop_i   (cls_pop),
    .cls_o       (cls),
    .cls_empty_o (cls_empty)
  );

  hus_back #(
    .Depth(QueueDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls),
    .cls_empty_i (cls_empty),
    .cls_pop_o   (cls_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign data_byte_o   = res.data_byte;
  assign part_o        = res.part;
  assign done_res_o    = res.done_res;
  assign status_o      = res.status;
  assign scheme_id_o   = res.scheme_id;
  assign port_number_o = res.port_number;

endmodule
